FILE: design/pmmu_pkg.sv
// Package for the paged MMU access unit: sizes, command and status codes,
// transaction payload types and the controller/datapath link structs.
// No dependencies; every other design file imports it.
package pmmu_pkg;

	localparam int TABLE_ENTRIES = 16;
	localparam int MEM_BYTES     = 4096;

	localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int ADDR_W = $clog2(MEM_BYTES);

	// Reciprocal for the remainder by MEM_BYTES: q = (x * MEM_RECIP) >> 32 is exact
	// for x < 2**16 since x * MEM_BYTES stays below 2**32.
	localparam int              RECIP_W   = 25;
	localparam logic [RECIP_W-1:0] MEM_RECIP =
		RECIP_W'((64'd1 << 32) / MEM_BYTES + 1);
	localparam int              QUOT_W    = 16 + RECIP_W - 32;
	localparam logic [16:0]     MEM_BYTES_V = 17'(MEM_BYTES);

	localparam logic [2:0] PSH_RESET = 3'd4;   // page size 16

	typedef enum logic [2:0] {
		CMD_FETCH,
		CMD_LOAD,
		CMD_STORE,
		CMD_TRANSLATE,
		CMD_WRITE_ENTRY,
		CMD_POKE
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_PAGE_FAULT,
		ST_SEGV,
		ST_ACCESS_VIOL
	} status_t;

	typedef struct packed {
		logic        modified;
		logic        referenced;
		logic        exec;
		logic        write;
		logic        read;
		logic        present;
		logic [7:0]  frame;
	} pte_t;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] address;
		logic [7:0]  write_byte;
		logic [3:0]  entry_index;
		logic [7:0]  entry_frame;
		logic        entry_present;
		logic        entry_read;
		logic        entry_write;
		logic        entry_exec;
	} req_item_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  read_byte;
		logic [15:0] phys_addr;
		logic        entry_referenced;
		logic        entry_modified;
	} rsp_item_t;

	// Controller to datapath.
	typedef struct packed {
		logic latch;
		logic check;
		logic div_q;
		logic div_r;
		logic access;
	} dp_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic need_div;
	} dp_stat_t;

endpackage

FILE: design/pmmu_intf.sv
// Handshake interfaces of the paged MMU access unit: request, response and
// configuration write channels. Depends on pmmu_pkg.
interface pmmu_req_if import pmmu_pkg::*; ();
	logic      valid;
	logic      ready;
	req_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface pmmu_rsp_if import pmmu_pkg::*; ();
	logic      valid;
	logic      ready;
	rsp_item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

interface pmmu_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

FILE: design/pmmu_ctrl.sv
// Sequencer of the paged MMU access unit: walks one transaction through the
// check step and, when needed, the remainder and memory access steps. Depends on pmmu_pkg.
module pmmu_ctrl import pmmu_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_DIVQ,
		S_DIVR,
		S_ACCESS,
		S_RESP
	} state_t;

	state_t state_q;
	logic   req_ready_q;
	logic   rsp_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			req_ready_q <= 1'b1;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q     <= S_CHECK;
						req_ready_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (stat.need_div) begin
						state_q <= S_DIVQ;
					end else begin
						state_q     <= S_RESP;
						rsp_valid_q <= 1'b1;
					end
				end
				S_DIVQ:   state_q <= S_DIVR;
				S_DIVR:   state_q <= S_ACCESS;
				S_ACCESS: begin
					state_q     <= S_RESP;
					rsp_valid_q <= 1'b1;
				end
				S_RESP: begin
					if (rsp_ready) begin
						state_q     <= S_IDLE;
						rsp_valid_q <= 1'b0;
						req_ready_q <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req_ready = req_ready_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		cmd        = '0;
		cmd.latch  = req_valid && req_ready_q;
		cmd.check  = (state_q == S_CHECK);
		cmd.div_q  = (state_q == S_DIVQ);
		cmd.div_r  = (state_q == S_DIVR);
		cmd.access = (state_q == S_ACCESS);
	end

endmodule

FILE: design/pmmu_datapath.sv
// Datapath of the paged MMU access unit: page-size register, page table,
// fault checks, remainder unit and byte memory. Depends on pmmu_pkg.
module pmmu_datapath import pmmu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_data,
	input  req_item_t  req,
	input  dp_cmd_t    cmd,
	output dp_stat_t   stat,
	output rsp_item_t  rsp
);

	logic [2:0]          psh_q;
	pte_t                pte_q [TABLE_ENTRIES];
	req_item_t           req_q;
	logic [IDX_W-1:0]    page_idx_q;
	logic [1:0]          status_q;
	logic                ref_q;
	logic                mod_q;
	logic                need_div_q;
	logic [15:0]         raw_q;
	logic [QUOT_W-1:0]   quot_q;
	logic [15:0]         phys_q;
	logic                rd_sel_q;
	logic [7:0]          rdata_q;
	logic [7:0]          mem [MEM_BYTES];

	logic [2:0]          cfg_sh;
	logic [7:0]          page;
	logic [8:0]          page_ext;
	logic [8:0]          ent_ext;
	logic [IDX_W-1:0]    page_idx;
	logic [IDX_W-1:0]    ent_idx;
	logic                in_tab;
	logic                ent_ok;
	pte_t                e;
	logic                mapped;
	logic                need_right;
	status_t             chk_status;
	logic [15:0]         offset;
	logic [15:0]         raw_map;
	logic [16+RECIP_W-1:0] quot_prod;
	logic [QUOT_W+17-1:0]  rem_prod;
	logic [15:0]         rem;
	logic                is_poke;
	logic                ok_rd;
	logic                ok_st;
	logic [ADDR_W-1:0]   mem_addr;
	logic                mem_we;
	logic                mem_re;

	// Floor log2 of the written page size; zero acts as one.
	always_comb begin
		cfg_sh = 3'd0;
		for (int i = 1; i < 8; i++) begin
			if (cfg_data[i]) cfg_sh = 3'(i);
		end
	end

	assign page     = 8'(req_q.address >> psh_q);
	assign page_ext = {1'b0, page};
	assign ent_ext  = {5'b0, req_q.entry_index};
	assign page_idx = page_ext[IDX_W-1:0];
	assign ent_idx  = ent_ext[IDX_W-1:0];
	assign in_tab   = (page_ext < 9'(TABLE_ENTRIES));
	assign ent_ok   = (ent_ext < 9'(TABLE_ENTRIES));
	assign e        = pte_q[page_idx];
	assign mapped   = (req_q.cmd == CMD_FETCH) || (req_q.cmd == CMD_LOAD) ||
	                  (req_q.cmd == CMD_STORE) || (req_q.cmd == CMD_TRANSLATE);
	assign is_poke  = (req_q.cmd == CMD_POKE);
	assign offset   = req_q.address & ((16'd1 << psh_q) - 16'd1);
	assign raw_map  = ({8'b0, e.frame} << psh_q) + offset;

	always_comb begin
		case (req_q.cmd)
			CMD_FETCH: need_right = e.exec;
			CMD_LOAD:  need_right = e.read;
			default:   need_right = e.write;
		endcase
	end

	always_comb begin
		if (!in_tab)
			chk_status = ST_SEGV;
		else if (!e.present)
			chk_status = ST_PAGE_FAULT;
		else if (req_q.cmd != CMD_TRANSLATE && !(e.read || e.write || e.exec))
			chk_status = ST_SEGV;
		else if (req_q.cmd != CMD_TRANSLATE && !need_right)
			chk_status = ST_ACCESS_VIOL;
		else
			chk_status = ST_OK;
	end

	assign quot_prod = raw_q * MEM_RECIP;
	assign rem_prod  = quot_q * MEM_BYTES_V;
	assign rem       = raw_q - rem_prod[15:0];

	assign ok_rd    = need_div_q && ((req_q.cmd == CMD_FETCH) || (req_q.cmd == CMD_LOAD));
	assign ok_st    = need_div_q && ((req_q.cmd == CMD_STORE) || (req_q.cmd == CMD_POKE));
	assign mem_addr = phys_q[ADDR_W-1:0];
	assign mem_we   = cmd.access && ok_st;
	assign mem_re   = cmd.access && ok_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			psh_q <= PSH_RESET;
			for (int i = 0; i < TABLE_ENTRIES; i++) pte_q[i] <= '0;
		end else begin
			if (cfg_we) psh_q <= cfg_sh;
			if (cmd.check && req_q.cmd == CMD_WRITE_ENTRY && ent_ok) begin
				pte_q[ent_idx] <= '{modified: 1'b0, referenced: 1'b0,
				                   exec: req_q.entry_exec, write: req_q.entry_write,
				                   read: req_q.entry_read, present: req_q.entry_present,
				                   frame: req_q.entry_frame};
			end
			if (cmd.access && mapped && need_div_q && req_q.cmd != CMD_TRANSLATE) begin
				pte_q[page_idx_q].referenced <= 1'b1;
				if (req_q.cmd == CMD_STORE) pte_q[page_idx_q].modified <= 1'b1;
			end
		end
	end

	// Payload and step registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) req_q <= req;
		if (cmd.check) begin
			page_idx_q <= page_idx;
			rd_sel_q   <= 1'b0;
			if (mapped) begin
				status_q   <= chk_status;
				ref_q      <= in_tab && e.referenced;
				mod_q      <= in_tab && e.modified;
				need_div_q <= (chk_status == ST_OK);
				raw_q      <= raw_map;
			end else begin
				status_q   <= ST_OK;
				ref_q      <= 1'b0;
				mod_q      <= 1'b0;
				need_div_q <= is_poke;
				raw_q      <= req_q.address;
			end
		end
		if (cmd.div_q) quot_q <= quot_prod[16+RECIP_W-1:32];
		if (cmd.div_r) phys_q <= rem;
		if (cmd.access) begin
			rd_sel_q <= ok_rd;
			if (mapped && req_q.cmd != CMD_TRANSLATE) begin
				ref_q <= 1'b1;
				if (req_q.cmd == CMD_STORE) mod_q <= 1'b1;
			end
		end
	end

	// Byte memory, one port, registered read.
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_addr] <= req_q.write_byte;
		if (mem_re) rdata_q <= mem[mem_addr];
	end

	assign stat.need_div = (mapped && chk_status == ST_OK) || is_poke;

	assign rsp.status           = status_q;
	assign rsp.read_byte        = rd_sel_q ? rdata_q : 8'd0;
	assign rsp.phys_addr        = need_div_q ? phys_q : 16'd0;
	assign rsp.entry_referenced = ref_q;
	assign rsp.entry_modified   = mod_q;

endmodule

FILE: design/paged_mmu_access_unit.sv
// Paged MMU access unit: page-table translation and checks over a byte memory.
// A fault, entry write or unused command goes from the check step straight to
// the response; an ok fetch/load/store/translate or a poke goes through check,
// two remainder steps and memory access first. One transaction is in flight at
// a time: a new request is taken only after the last response is accepted.
// Reset (arst_n, async): page table cleared, page size 16; memory not cleared.
module paged_mmu_access_unit import pmmu_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	pmmu_cfg_if.sink   cfg,
	pmmu_req_if.sink   req,
	pmmu_rsp_if.source rsp
);

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	// Page size writes land at once; host must write only while idle; unchecked.
	assign cfg.ready = 1'b1;

	// Controller: owns the request/response handshakes and steps the datapath.
	pmmu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// Datapath: holds the captured transaction, page table, and the memory;
	// its result registers stay stable while the response waits.
	pmmu_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.req      (req.payload),
		.cmd      (dp_cmd),
		.stat     (dp_stat),
		.rsp      (rsp.payload)
	);

endmodule
